/* hdl/rlfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlfr_pkg;

    localparam int COLS_MAX_DEF   = 1024;
    localparam int LAYERS_MAX_DEF = 16;
    localparam int SINE_ENTRIES   = 1024;

    localparam logic [16:0] FULL_TURN = 17'd32768;
    localparam logic [16:0] HALF_TURN = 17'd16384;
    localparam logic [16:0] EIGHTH    = 17'd4096;

    // input request
    typedef struct packed {
        logic [15:0] aspect;
        logic        no_outlet;
        logic [9:0]  slope_index;
        logic [15:0] ksat;
        logic [15:0] content;
        logic [15:0] content_max;
    } cell_in_t;

    // result request
    typedef struct packed {
        logic [9:0]  out_row;
        logic [9:0]  out_col;
        logic [3:0]  out_layer;
        logic [18:0] inflow;
        logic [15:0] outflow;
        logic        last;
    } flow_out_t;

    // line store / window entry
    typedef struct packed {
        logic [15:0] aspect;
        logic [15:0] cmax;
        logic [15:0] content;
        logic [15:0] oflow;
    } cell_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [3:0] layer;
        logic       last;
    } pos_t;

    // window stage to accumulator
    typedef struct packed {
        logic [7:0][12:0] weight;
        logic [7:0][15:0] nb_out;
        logic [15:0]      ctr_out;
        pos_t             pos;
    } nbr_t;

    typedef enum logic [1:0] {
        CFG_ROWS   = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_LAYERS = 2'd2
    } cfg_idx_t;

    // direction from each window position back to the center
    localparam logic [14:0] DIR_TO_CTR [9] = '{
        15'd28672, 15'd24576, 15'd20480,
        15'd0,     15'd0,     15'd16384,
        15'd4096,  15'd8192,  15'd12288
    };

    typedef logic [16:0] sine_tab_t [SINE_ENTRIES];

    // Q30 Taylor series to x^13, rounded to Q16
    function automatic logic [16:0] sine_q16(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        int                 n;
        x    = (64'd1686629713 * 64'(k)) / 64'(SINE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (64'(sum) + 64'd8192) >> 14;
        return (q > 64'd65536) ? 17'd65536 : q[16:0];
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t t;
        for (int k = 0; k < SINE_ENTRIES; k++)
            t[k] = sine_q16(k);
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

`default_nettype wire

/* hdl/rlfr_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two previous rows, one 128-bit word per column: {row r-2, row r-1}.
module rlfr_line_store #(
    parameter int COLS_MAX = rlfr_pkg::COLS_MAX_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(COLS_MAX)-1:0] rd_addr,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(COLS_MAX)-1:0] wr_addr,
    input  wire rlfr_pkg::cell_t             wr_up1,
    input  wire rlfr_pkg::cell_t             wr_cell,
    output rlfr_pkg::cell_t                  rd_up2,
    output rlfr_pkg::cell_t                  rd_up1
);
    import rlfr_pkg::*;

    logic [127:0] mem [COLS_MAX];
    logic [127:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_up1, wr_cell};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign rd_up2 = cell_t'(rd_reg[127:64]);
    assign rd_up1 = cell_t'(rd_reg[63:0]);

endmodule

`default_nettype wire

/* hdl/rlfr_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// 3x3 window and per-neighbour weights.
module rlfr_window (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            emit,
    input  wire rlfr_pkg::pos_t  pos,
    input  wire rlfr_pkg::cell_t new_cell,
    input  wire rlfr_pkg::cell_t up1,
    input  wire rlfr_pkg::cell_t up2,
    input  wire logic            acc_ready,
    output logic                 s2_ready,
    output logic                 s2_valid,
    output rlfr_pkg::nbr_t       s2_data
);
    import rlfr_pkg::*;

    cell_t win_reg  [9];
    cell_t win_next [9];
    logic  s2_v_reg;
    nbr_t  s2_reg;
    nbr_t  s2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            win_next[i * 3]     = win_reg[i * 3 + 1];
            win_next[i * 3 + 1] = win_reg[i * 3 + 2];
        end
        win_next[2] = up2;
        win_next[5] = up1;
        win_next[8] = new_cell;
    end

    always_comb
    begin
        int          k;
        logic [16:0] a;
        logic [16:0] dir;
        logic [16:0] d;
        logic        hit;
        s2_next = '0;
        for (int j = 0; j < 8; j++) begin
            k   = (j < 4) ? j : j + 1;
            a   = {1'b0, win_next[k].aspect};
            dir = {2'b00, DIR_TO_CTR[k]};
            d   = (a > dir) ? a - dir : dir - a;
            if (d > HALF_TURN)
                d = FULL_TURN - d;
            hit = (a <= FULL_TURN) && (win_next[k].content == win_next[4].cmax)
                  && (d < EIGHTH);
            s2_next.weight[j] = hit ? 13'(EIGHTH - d) : 13'd0;
            s2_next.nb_out[j] = win_next[k].oflow;
        end
        s2_next.ctr_out = win_next[4].oflow;
        s2_next.pos     = pos;
    end

    assign s2_ready = !s2_v_reg || acc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_v_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end else begin
            if (adv) begin
                for (int i = 0; i < 9; i++)
                    win_reg[i] <= win_next[i];
            end
            if (adv && emit)
                s2_v_reg <= 1'b1;
            else if (acc_ready)
                s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
            s2_reg <= s2_next;
    end

    assign s2_valid = s2_v_reg;
    assign s2_data  = s2_reg;

endmodule

`default_nettype wire

/* hdl/rlfr_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

// Weighted products, pair sums, final sum with saturation, output register.
module rlfr_accum (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire rlfr_pkg::nbr_t in_data,
    output logic                in_ready,
    output logic                flow_valid,
    input  wire logic           flow_stall,
    output rlfr_pkg::flow_out_t flow
);
    import rlfr_pkg::*;

    logic             s3_v_reg, s4_v_reg, o_v_reg;
    logic [7:0][28:0] prod_reg;
    logic [3:0][29:0] pair_reg;
    logic [15:0]      s3_ctr_reg, s4_ctr_reg;
    pos_t             s3_pos_reg, s4_pos_reg;
    flow_out_t        o_reg;
    flow_out_t        o_next;
    logic [31:0]      total;
    logic [19:0]      total_sh;
    logic             o_ready, s4_ready, s3_ready;

    assign o_ready  = !o_v_reg || !flow_stall;
    assign s4_ready = !s4_v_reg || o_ready;
    assign s3_ready = !s3_v_reg || s4_ready;
    assign in_ready = s3_ready;

    always_comb
    begin
        total    = 32'(pair_reg[0]) + 32'(pair_reg[1]) + 32'(pair_reg[2])
                 + 32'(pair_reg[3]);
        total_sh = total[31:12];
        o_next.out_row   = s4_pos_reg.row;
        o_next.out_col   = s4_pos_reg.col;
        o_next.out_layer = s4_pos_reg.layer;
        o_next.inflow    = total_sh[19] ? '1 : total_sh[18:0];
        o_next.outflow   = s4_ctr_reg;
        o_next.last      = s4_pos_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else begin
            if (s3_ready)
                s3_v_reg <= in_valid;
            if (s4_ready)
                s4_v_reg <= s3_v_reg;
            if (o_ready)
                o_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s3_ready) begin
            for (int j = 0; j < 8; j++)
                prod_reg[j] <= in_data.nb_out[j] * in_data.weight[j];
            s3_ctr_reg <= in_data.ctr_out;
            s3_pos_reg <= in_data.pos;
        end
        if (s3_v_reg && s4_ready) begin
            for (int j = 0; j < 4; j++)
                pair_reg[j] <= 30'(prod_reg[2 * j]) + 30'(prod_reg[2 * j + 1]);
            s4_ctr_reg <= s3_ctr_reg;
            s4_pos_reg <= s3_pos_reg;
        end
        if (s4_v_reg && o_ready)
            o_reg <= o_next;
    end

    assign flow_valid = o_v_reg;
    assign flow       = o_reg;

endmodule

`default_nettype wire

/* hdl/raster_lateral_flow_router.sv */
`timescale 1ns / 1ps
`default_nettype none

// A result passes the stage 1, window, product, pair-sum and output registers in that order.
// Throughput: one cell per cycle while cell_stall is low; the line store takes one read and one write each cycle.
// Reset: counters, window and pipeline valids clear; rows = cols = 3, layers = 1.
// Line store contents are undefined after reset; no clearing pass, rows 0 and 1 of
// every frame fill it before any result depends on it.
module raster_lateral_flow_router #(
    parameter int COLS_MAX   = rlfr_pkg::COLS_MAX_DEF,
    parameter int LAYERS_MAX = rlfr_pkg::LAYERS_MAX_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // cell requests
    input  wire logic                cell_valid,
    output logic                     cell_stall,
    input  wire rlfr_pkg::cell_in_t  raster_cell,
    // result requests
    output logic                     flow_valid,
    input  wire logic                flow_stall,
    output rlfr_pkg::flow_out_t      flow,
    // configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [10:0]         cfg_data
);
    import rlfr_pkg::*;

    localparam int AW     = $clog2(COLS_MAX);
    localparam int COL_HI = (COLS_MAX < 1024) ? COLS_MAX : 1024;
    localparam int LAY_HI = (LAYERS_MAX < 16) ? LAYERS_MAX : 16;

    // configuration
    logic [10:0] rows_reg, cols_reg;
    logic [4:0]  layers_reg;
    logic [10:0] nr, nc;
    logic [4:0]  nl;
    logic        cfg_wr;

    // raster position of the next cell
    logic [9:0] row_reg, col_reg;
    logic [3:0] layer_reg;
    logic [9:0] row_next, col_next;
    logic [3:0] layer_next;

    // stage 1: line store read in flight, outflow multiply
    logic        s1_v_reg;
    logic [15:0] s1_aspect_reg, s1_content_reg, s1_cmax_reg, s1_ksat_reg;
    logic [16:0] s1_sine_reg;
    logic        s1_oen_reg, s1_emit_reg;
    pos_t        s1_pos_reg;
    logic [9:0]  s1_col_reg;

    logic        accept, adv1, s1_ready;
    logic        row_first, row_end, col_first, col_end, lay_end;
    logic        interior, emit;
    pos_t        pos_in;
    logic [32:0] oflow_prod;
    logic [16:0] oflow_wide;
    cell_t       s1_cell;
    cell_t       up1, up2;
    logic        s2_ready, s2_valid, acc_ready;
    nbr_t        s2_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // effective sizes, clamped to legal ranges
    always_comb
    begin
        nr = (rows_reg < 11'd3) ? 11'd3 : (rows_reg > 11'd1024) ? 11'd1024 : rows_reg;
        nc = (cols_reg < 11'd3) ? 11'd3
           : (cols_reg > 11'(COL_HI)) ? 11'(COL_HI) : cols_reg;
        nl = (layers_reg < 5'd1) ? 5'd1
           : (layers_reg > 5'(LAY_HI)) ? 5'(LAY_HI) : layers_reg;
    end

    always_comb
    begin
        row_first = (row_reg == 10'd0);
        col_first = (col_reg == 10'd0);
        row_end   = ({1'b0, row_reg} == nr - 11'd1);
        col_end   = ({1'b0, col_reg} == nc - 11'd1);
        lay_end   = ({1'b0, layer_reg} == nl - 5'd1);
        interior  = !row_first && !row_end && !col_first && !col_end;
        emit      = (row_reg >= 10'd2) && (col_reg >= 10'd2);
        pos_in.row   = row_reg - 10'd1;
        pos_in.col   = col_reg - 10'd1;
        pos_in.layer = layer_reg;
        pos_in.last  = row_end && col_end && lay_end;

        row_next   = row_reg;
        col_next   = col_reg + 10'd1;
        layer_next = layer_reg;
        if (col_end) begin
            col_next = 10'd0;
            row_next = row_reg + 10'd1;
            if (row_end) begin
                row_next   = 10'd0;
                layer_next = lay_end ? 4'd0 : layer_reg + 4'd1;
            end
        end
    end

    // handshake: stage 1 frees when it moves on; items without a result need no slot
    assign adv1       = s1_v_reg && (!s1_emit_reg || s2_ready);
    assign s1_ready   = !s1_v_reg || adv1;
    assign cell_stall = !s1_ready;
    assign accept     = cell_valid && !cell_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rows_reg   <= 11'd3;
            cols_reg   <= 11'd3;
            layers_reg <= 5'd1;
            row_reg    <= '0;
            col_reg    <= '0;
            layer_reg  <= '0;
            s1_v_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ROWS:   rows_reg   <= cfg_data;
                    CFG_COLS:   cols_reg   <= cfg_data;
                    CFG_LAYERS: layers_reg <= cfg_data[4:0];
                    default:    ;
                endcase
                // any known register restarts the raster
                if (cfg_idx_t'(cfg_index) == CFG_ROWS || cfg_idx_t'(cfg_index) == CFG_COLS
                    || cfg_idx_t'(cfg_index) == CFG_LAYERS) begin
                    row_reg   <= '0;
                    col_reg   <= '0;
                    layer_reg <= '0;
                end
            end else if (accept) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                layer_reg <= layer_next;
            end
            if (s1_ready)
                s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_aspect_reg  <= raster_cell.aspect;
            s1_content_reg <= raster_cell.content;
            s1_cmax_reg    <= raster_cell.content_max;
            s1_ksat_reg    <= raster_cell.ksat;
            s1_sine_reg    <= SINE_TAB[raster_cell.slope_index];
            s1_oen_reg     <= interior && !raster_cell.no_outlet
                              && (raster_cell.slope_index != 10'd0)
                              && (raster_cell.content == raster_cell.content_max);
            s1_emit_reg    <= emit;
            s1_pos_reg     <= pos_in;
            s1_col_reg     <= col_reg;
        end
    end

    // outflow = ksat * sin(slope), Q16 truncated, saturated to 16 bits; zero unless the outlet is enabled
    always_comb
    begin
        oflow_prod = s1_ksat_reg * s1_sine_reg;
        oflow_wide = oflow_prod[32:16];
        s1_cell.aspect  = s1_aspect_reg;
        s1_cell.cmax    = s1_cmax_reg;
        s1_cell.content = s1_content_reg;
        s1_cell.oflow   = !s1_oen_reg ? 16'd0 : oflow_wide[16] ? 16'hFFFF : oflow_wide[15:0];
    end

    // read-modify-write: read at accept, write back when the cell leaves stage 1
    rlfr_line_store #(
        .COLS_MAX(COLS_MAX)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (AW'(col_reg)),
        .wr_en   (adv1),
        .wr_addr (AW'(s1_col_reg)),
        .wr_up1  (up1),
        .wr_cell (s1_cell),
        .rd_up2  (up2),
        .rd_up1  (up1)
    );

    rlfr_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv1),
        .emit      (s1_emit_reg),
        .pos       (s1_pos_reg),
        .new_cell  (s1_cell),
        .up1       (up1),
        .up2       (up2),
        .acc_ready (acc_ready),
        .s2_ready  (s2_ready),
        .s2_valid  (s2_valid),
        .s2_data   (s2_data)
    );

    rlfr_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_data    (s2_data),
        .in_ready   (acc_ready),
        .flow_valid (flow_valid),
        .flow_stall (flow_stall),
        .flow       (flow)
    );

endmodule

`default_nettype wire
